// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ===== rtl/npcm_pkg.sv =====
// ---------------------------------------------------------------------------
// npcm_pkg
// Constants and palette ROM for the nearest palette colour matcher.
// ---------------------------------------------------------------------------
package npcm_pkg;

	localparam int COLOURS_DEF = 16;
	localparam int TABLES_DEF  = 8;
	localparam int ROM_TABLES  = 8;
	localparam int ROM_COLOURS = 16;

	localparam int SEL_W   = 3;   // palette_select width
	localparam int PIX_W   = 24;  // pixel_rgb width
	localparam int IDX_W   = 4;   // colour_index width
	localparam int CH_W    = 8;   // one colour channel
	localparam int WGT_W   = 10;  // weight 512+m or 767-m
	localparam int SQ_W    = 16;  // square of a channel difference
	localparam int PROD_W  = WGT_W + SQ_W;
	localparam int TERM_W  = 18;  // one term of the distance
	localparam int DIST_W  = 20;  // full distance, max about 585000

	localparam logic [WGT_W-1:0] RED_BIAS  = 10'd512;
	localparam logic [WGT_W-1:0] BLUE_BIAS = 10'd767;

	typedef logic [PIX_W-1:0] rgb_t;

	// Constant palette tables, red in 23:16, green 15:8, blue 7:0.
	localparam rgb_t PAL_ROM [ROM_TABLES][ROM_COLOURS] = '{
		'{24'h000000, 24'hffffff, 24'h894036, 24'h7abfc7,
		  24'h8a46ae, 24'h68a941, 24'h3e31a2, 24'hd0dc71,
		  24'h905f25, 24'h5c4700, 24'hbb776d, 24'h555555,
		  24'h808080, 24'hacea88, 24'h7c70da, 24'hababab},
		'{24'h000000, 24'hFFFFFF, 24'h68372B, 24'h70A4B2,
		  24'h6F3D86, 24'h588D43, 24'h352879, 24'hB8C76F,
		  24'h6F4F25, 24'h433900, 24'h9A6759, 24'h444444,
		  24'h6C6C6C, 24'h9AD284, 24'h6C5EB5, 24'h959595},
		'{24'h0A0A0A, 24'hFFF8FF, 24'h851F02, 24'h65CDA8,
		  24'hA73B9F, 24'h4DAB19, 24'h1A0C92, 24'hEBE353,
		  24'hA94B02, 24'h441E00, 24'hD28074, 24'h464646,
		  24'h8B8B8B, 24'h8EF68E, 24'h4D91D1, 24'hBABABA},
		'{24'h000000, 24'hFCFCFC, 24'hA80000, 24'h54FCFC,
		  24'hA800A8, 24'h00A800, 24'h0000A8, 24'hFCFC00,
		  24'hA85400, 24'h802C00, 24'hFC5454, 24'h545454,
		  24'h808080, 24'h54FC54, 24'h5454FC, 24'hA8A8A8},
		'{24'h101010, 24'hFFFFFF, 24'hE04040, 24'h60FFFF,
		  24'hE060E0, 24'h40E040, 24'h4040E0, 24'hFFFF40,
		  24'hE0A040, 24'h9C7448, 24'hFFA0A0, 24'h545454,
		  24'h888888, 24'hA0FFA0, 24'hA0A0FF, 24'hC0C0C0},
		'{24'h000000, 24'hFFFFFF, 24'hCC0000, 24'h00FFCC,
		  24'hFF00FF, 24'h00CC00, 24'h0000CC, 24'hFFFF00,
		  24'hFF8800, 24'h884400, 24'hFF8888, 24'h444444,
		  24'h888888, 24'h88FF88, 24'h8888FF, 24'hCCCCCC},
		'{24'h000000, 24'hFFFFFF, 24'h880000, 24'hAAFFEE,
		  24'hCC44CC, 24'h00CC55, 24'h0000AA, 24'hEEEE77,
		  24'hDD8855, 24'h664400, 24'hFE7777, 24'h333333,
		  24'h777777, 24'hAAFF66, 24'h0088FF, 24'hBBBBBB},
		'{24'h212121, 24'hFFFFFF, 24'hB52121, 24'h73FFFF,
		  24'hB521B5, 24'h21B521, 24'h2121B5, 24'hFFFF21,
		  24'hB57321, 24'h944221, 24'hFF7373, 24'h737373,
		  24'h949494, 24'h73FF73, 24'h7373FF, 24'hB5B5B5}
	};

	// Sequencer states, one-hot.
	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SQ_R = 7'b0000010,
		ST_W_R  = 7'b0000100,
		ST_SQ_G = 7'b0001000,
		ST_SQ_B = 7'b0010000,
		ST_W_B  = 7'b0100000,
		ST_CMP  = 7'b1000000
	} state_t;

endpackage

// ===== rtl/nearest_palette_colour_match.sv =====
// ---------------------------------------------------------------------------
// nearest_palette_colour_match
// Finds the nearest of the palette colours to an RGB pixel, redmean metric.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one pixel per item, red 23:16, green 15:8, blue 7:0.
//   Output channel m_*: one palette index per item, lowest index on ties.
//   cfg_wen/cfg_wdata write palette_select; write only while the block idles.
//   Values at or above PALETTE_TABLES select the last table present.
// Sequence:
//   Each palette entry is processed in steps on the single 10x16 multiplier:
//   red square, red weight, green square, blue square, blue weight, compare.
//   The result is registered at the last entry's compare; s_tready is high
//   only while idle, so a new item is taken only after the current one has
//   left its final compare.
// Reset:
//   arst_n clears the sequencer, the output valid and palette_select to 0.
// Stall:
//   A result waits in the output register; a new item is accepted meanwhile
//   and runs until its final compare, where it holds until the slot is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_palette_colour_match #(
	parameter int PALETTE_COLOURS = npcm_pkg::COLOURS_DEF,
	parameter int PALETTE_TABLES  = npcm_pkg::TABLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_wdata,  // palette_select
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [23:0] pixel_rgb
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata     // [3:0] colour_index, [7:4] zero
);

	localparam int CNT_W = (PALETTE_COLOURS > 1) ? $clog2(PALETTE_COLOURS) : 1;
	localparam logic [CNT_W-1:0] LAST_ENTRY = CNT_W'(PALETTE_COLOURS - 1);

	npcm_pkg::state_t state_q;

	logic [npcm_pkg::SEL_W-1:0]  palette_select_q;
	logic [npcm_pkg::SEL_W-1:0]  sel_eff;
	npcm_pkg::rgb_t              pix_q;
	npcm_pkg::rgb_t              pal_col;
	logic [CNT_W-1:0]            entry_q;
	logic                        last_entry;
	logic [npcm_pkg::PROD_W-1:0] prod_q;
	logic [npcm_pkg::DIST_W-1:0] acc_q;
	logic [npcm_pkg::DIST_W-1:0] best_q;
	logic [npcm_pkg::IDX_W-1:0]  best_idx_q;
	logic [npcm_pkg::IDX_W-1:0]  out_idx_q;
	logic                        out_valid_q;

	logic [npcm_pkg::CH_W-1:0]   dr, dg, db;
	logic [npcm_pkg::CH_W-1:0]   mean_r;
	logic [npcm_pkg::CH_W:0]     red_sum;
	logic [npcm_pkg::WGT_W-1:0]  mul_a;
	logic [npcm_pkg::SQ_W-1:0]   mul_b;
	logic [npcm_pkg::DIST_W-1:0] entry_dist;
	logic                        take;
	logic                        out_free;
	logic [npcm_pkg::IDX_W-1:0]  entry_idx;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		abs_diff = (a > b) ? (a - b) : (b - a);
	endfunction

	// Table select with clamp to the tables present
	always_comb begin
		if ({1'b0, palette_select_q} >= 4'(PALETTE_TABLES)) begin
			sel_eff = npcm_pkg::SEL_W'(PALETTE_TABLES - 1);
		end else begin
			sel_eff = palette_select_q;
		end
	end

	assign entry_idx  = npcm_pkg::IDX_W'(entry_q);
	assign pal_col    = npcm_pkg::PAL_ROM[sel_eff][entry_idx];
	assign last_entry = (entry_q == LAST_ENTRY);

	// Channel differences and floored mean red
	assign dr      = abs_diff(pix_q[23:16], pal_col[23:16]);
	assign dg      = abs_diff(pix_q[15:8],  pal_col[15:8]);
	assign db      = abs_diff(pix_q[7:0],   pal_col[7:0]);
	assign red_sum = {1'b0, pix_q[23:16]} + {1'b0, pal_col[23:16]};
	assign mean_r  = red_sum[npcm_pkg::CH_W:1];

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			npcm_pkg::ST_SQ_R: begin
				mul_a = {2'b00, dr};
				mul_b = {8'h00, dr};
			end
			npcm_pkg::ST_W_R: begin
				mul_a = npcm_pkg::RED_BIAS + {2'b00, mean_r};
				mul_b = prod_q[npcm_pkg::SQ_W-1:0];
			end
			npcm_pkg::ST_SQ_G: begin
				mul_a = {2'b00, dg};
				mul_b = {8'h00, dg};
			end
			npcm_pkg::ST_SQ_B: begin
				mul_a = {2'b00, db};
				mul_b = {8'h00, db};
			end
			npcm_pkg::ST_W_B: begin
				mul_a = npcm_pkg::BLUE_BIAS - {2'b00, mean_r};
				mul_b = prod_q[npcm_pkg::SQ_W-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Final distance of the current entry and compare
	assign entry_dist = acc_q + npcm_pkg::DIST_W'(prod_q[npcm_pkg::PROD_W-1:8]);
	assign take       = (entry_q == '0) || (entry_dist < best_q);
	assign out_free   = !out_valid_q || m_tready;

	assign s_tready = (state_q == npcm_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_idx_q};

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_select_q <= '0;
		end else if (cfg_wen) begin
			palette_select_q <= cfg_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npcm_pkg::ST_IDLE;
			entry_q <= '0;
		end else begin
			unique case (state_q)
				npcm_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= npcm_pkg::ST_SQ_R;
						entry_q <= '0;
					end
				end
				npcm_pkg::ST_SQ_R: state_q <= npcm_pkg::ST_W_R;
				npcm_pkg::ST_W_R:  state_q <= npcm_pkg::ST_SQ_G;
				npcm_pkg::ST_SQ_G: state_q <= npcm_pkg::ST_SQ_B;
				npcm_pkg::ST_SQ_B: state_q <= npcm_pkg::ST_W_B;
				npcm_pkg::ST_W_B:  state_q <= npcm_pkg::ST_CMP;
				npcm_pkg::ST_CMP: begin
					if (!last_entry) begin
						state_q <= npcm_pkg::ST_SQ_R;
						entry_q <= entry_q + 1'b1;
					end else if (out_free) begin
						state_q <= npcm_pkg::ST_IDLE;
					end
				end
				default: state_q <= npcm_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath: pixel capture, product, accumulator, running best
	always_ff @(posedge clk) begin
		if (state_q == npcm_pkg::ST_IDLE && s_tvalid) begin
			pix_q <= s_tdata;
		end
		if (state_q == npcm_pkg::ST_SQ_R || state_q == npcm_pkg::ST_W_R ||
		    state_q == npcm_pkg::ST_SQ_G || state_q == npcm_pkg::ST_SQ_B ||
		    state_q == npcm_pkg::ST_W_B) begin
			prod_q <= npcm_pkg::PROD_W'(mul_a * mul_b);
		end
		// red term lands in SQ_G, green term is added in SQ_B
		if (state_q == npcm_pkg::ST_SQ_G) begin
			acc_q <= npcm_pkg::DIST_W'(prod_q[npcm_pkg::PROD_W-1:8]);
		end else if (state_q == npcm_pkg::ST_SQ_B) begin
			acc_q <= acc_q + npcm_pkg::DIST_W'({prod_q[npcm_pkg::SQ_W-1:0], 2'b00});
		end
		if (state_q == npcm_pkg::ST_CMP && take && (!last_entry || out_free)) begin
			best_q     <= entry_dist;
			best_idx_q <= entry_idx;
		end
		if (state_q == npcm_pkg::ST_CMP && last_entry && out_free) begin
			out_idx_q <= take ? entry_idx : best_idx_q;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == npcm_pkg::ST_CMP && last_entry && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Checks
	`ASSERT_CLK(a_start_at_entry0, clk, arst_n, (s_tvalid && s_tready) |=> (state_q == npcm_pkg::ST_SQ_R && entry_q == '0), "accepted item does not start at entry 0")
	`ASSERT_CLK(a_result_from_last_cmp, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == npcm_pkg::ST_CMP && last_entry), "result not issued from the last compare")
	`ASSERT_NEVER(a_entry_range, clk, arst_n, entry_q > LAST_ENTRY, "entry counter beyond palette size")
	`ASSERT_CLK(a_square_bound, clk, arst_n, (state_q == npcm_pkg::ST_W_R || state_q == npcm_pkg::ST_W_B) |-> (prod_q <= npcm_pkg::PROD_W'(65025)), "channel square out of range")

endmodule
